// ===== hw/rtl/mgla_pkg.sv =====
`default_nettype none

package mgla_pkg;

    localparam int ACCEL_BITS = 16;
    localparam int LIGHT_BITS = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_MOTION_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_DIVIDER    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_DIVIDER    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ON_TICKS         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OFF_TICKS        = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_TONE_FREQUENCY   = 3'd6;

    localparam logic [15:0] RST_MOTION_THRESHOLD = 16'd200;
    localparam logic [23:0] RST_LIGHT_THRESHOLD  = 24'd300;
    localparam logic [7:0]  RST_ACCEL_DIVIDER    = 8'd2;
    localparam logic [7:0]  RST_LIGHT_DIVIDER    = 8'd25;
    localparam logic [15:0] RST_ON_TICKS         = 16'd200;
    localparam logic [15:0] RST_OFF_TICKS        = 16'd400;
    localparam logic [15:0] RST_TONE_FREQUENCY   = 16'd3156;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;

    typedef struct packed {
        logic signed [ACCEL_BITS-1:0] accel_x;
        logic signed [ACCEL_BITS-1:0] accel_y;
        logic signed [ACCEL_BITS-1:0] accel_z;
        logic [LIGHT_BITS-1:0]        light_level;
    } mgla_in_t;

    typedef struct packed {
        logic        buzzer_on;
        logic [15:0] tone_hz;
        logic [1:0]  mode;
        logic        armed;
        logic [15:0] magnitude;
    } mgla_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/motion_gated_light_alarm.sv =====
// Motion-gated light alarm, one input request per sensor tick.
//
// s_ channel: one tick with three accelerometer axes and a light reading.
// m_ channel: one result per tick with buzzer state, tone, mode, armed flag
// and the last stored acceleration magnitude.
// cfg port: write cfg_data to register cfg_index when cfg_write_en is high;
// indexes beyond the register list are dropped.
//
// A tick that runs the motion check passes after acceptance through the
// shared squaring multiplier, the digit-by-digit square root, a register
// that hands the root over, and the state that updates the alarm.
// Any other tick goes straight to that update state. In that state the
// result is registered once the output register is free. s_ready stays low
// until the result is registered, so a new request is not accepted before
// the last one's result has been registered.
//
// Reset loads the register defaults and clears all alarm state.
// A finished result waits in the output register while the next request is
// accepted; that request completes only once the register has been taken.

`default_nettype none

module motion_gated_light_alarm
    import mgla_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire mgla_in_t               s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output mgla_out_t                   m_data,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int LT_W = (LIGHT_BITS > 24) ? LIGHT_BITS : 24;

    typedef enum logic [2:0] {
        ST_READY  = 3'b001,
        ST_ROOT   = 3'b010,
        ST_FINISH = 3'b100
    } seq_state_t;

    logic [15:0] motion_threshold_reg;
    logic [23:0] light_threshold_reg;
    logic [7:0]  accel_divider_reg;
    logic [7:0]  light_divider_reg;
    logic [15:0] on_ticks_reg;
    logic [15:0] off_ticks_reg;
    logic [15:0] tone_frequency_reg;

    seq_state_t            state_reg, state_next;
    logic [1:0]            mode_reg, mode_next;
    logic [7:0]            accel_phase_reg, accel_phase_next;
    logic [7:0]            light_phase_reg, light_phase_next;
    logic                  motion_flag_reg, motion_flag_next;
    logic [15:0]           last_mag_reg, last_mag_next;
    logic [LIGHT_BITS-1:0] last_light_reg, last_light_next;
    logic [15:0]           phase_timer_reg, phase_timer_next;
    logic                  m_valid_reg;
    mgla_out_t             m_data_reg, out_next;

    logic                  motion_run_reg;
    logic [LIGHT_BITS-1:0] light_in_reg;
    logic [15:0]           mag_in_reg;

    logic        in_accept, out_free, mag_start, mag_done;
    logic [15:0] mag_value;
    logic        run_motion;

    logic [15:0]           mag_diff;
    logic [LIGHT_BITS-1:0] light_rise, light_dist;
    logic [8:0]            accel_inc, light_inc;
    logic [15:0]           phase_len;
    logic [16:0]           timer_inc;
    logic                  trigger;

    assign s_ready    = (state_reg == ST_READY);
    assign in_accept  = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign run_motion = (mode_reg == MODE_IDLE) && (accel_phase_reg == 8'd0) && !motion_flag_reg;
    assign mag_start  = in_accept && run_motion;

    mgla_magnitude #(
        .ACCEL_W(ACCEL_BITS)
    ) u_magnitude (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mag_start),
        .axis_x   (s_data.accel_x),
        .axis_y   (s_data.accel_y),
        .axis_z   (s_data.accel_z),
        .done     (mag_done),
        .magnitude(mag_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motion_threshold_reg <= RST_MOTION_THRESHOLD;
            light_threshold_reg  <= RST_LIGHT_THRESHOLD;
            accel_divider_reg    <= RST_ACCEL_DIVIDER;
            light_divider_reg    <= RST_LIGHT_DIVIDER;
            on_ticks_reg         <= RST_ON_TICKS;
            off_ticks_reg        <= RST_OFF_TICKS;
            tone_frequency_reg   <= RST_TONE_FREQUENCY;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                REG_MOTION_THRESHOLD: motion_threshold_reg <= cfg_data[15:0];
                REG_LIGHT_THRESHOLD:  light_threshold_reg  <= cfg_data[23:0];
                REG_ACCEL_DIVIDER:    accel_divider_reg    <= cfg_data[7:0];
                REG_LIGHT_DIVIDER:    light_divider_reg    <= cfg_data[7:0];
                REG_ON_TICKS:         on_ticks_reg         <= cfg_data[15:0];
                REG_OFF_TICKS:        off_ticks_reg        <= cfg_data[15:0];
                REG_TONE_FREQUENCY:   tone_frequency_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        accel_phase_next = accel_phase_reg;
        light_phase_next = light_phase_reg;
        motion_flag_next = motion_flag_reg;
        last_mag_next    = last_mag_reg;
        last_light_next  = last_light_reg;
        phase_timer_next = phase_timer_reg;
        trigger          = 1'b0;

        mag_diff   = (mag_in_reg >= last_mag_reg) ? (mag_in_reg - last_mag_reg)
                                                  : (last_mag_reg - mag_in_reg);
        light_rise = light_in_reg - last_light_reg;
        light_dist = (light_in_reg >= last_light_reg) ? (light_in_reg - last_light_reg)
                                                      : (last_light_reg - light_in_reg);
        accel_inc  = {1'b0, accel_phase_reg} + 9'd1;
        light_inc  = {1'b0, light_phase_reg} + 9'd1;
        phase_len  = (mode_reg == MODE_ON) ? on_ticks_reg : off_ticks_reg;
        timer_inc  = {1'b0, phase_timer_reg} + 17'd1;

        unique case (state_reg)
            ST_READY: begin
                if (in_accept) begin
                    state_next = run_motion ? ST_ROOT : ST_FINISH;
                end
            end
            ST_ROOT: begin
                if (mag_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_READY;
                    if (mode_reg == MODE_IDLE) begin
                        if (motion_run_reg) begin
                            if (mag_diff > motion_threshold_reg) begin
                                motion_flag_next = 1'b1;
                            end
                            last_mag_next = mag_in_reg;
                        end
                        if ((light_phase_reg == 8'd0) && motion_flag_next) begin
                            trigger = (light_in_reg > last_light_reg) &&
                                      (LT_W'(light_rise) > LT_W'(light_threshold_reg));
                            last_light_next = light_in_reg;
                        end
                        accel_phase_next = (accel_inc >= {1'b0, accel_divider_reg}) ? 8'd0
                                                                                  : accel_inc[7:0];
                        light_phase_next = (light_inc >= {1'b0, light_divider_reg}) ? 8'd0
                                                                                  : light_inc[7:0];
                        if (trigger) begin
                            mode_next        = MODE_ON;
                            motion_flag_next = 1'b0;
                            phase_timer_next = 16'd0;
                        end
                    end else begin
                        if (timer_inc >= {1'b0, phase_len}) begin
                            phase_timer_next = 16'd0;
                            if (LT_W'(light_dist) > LT_W'(light_threshold_reg)) begin
                                mode_next       = MODE_IDLE;
                                last_light_next = '0;
                                last_mag_next   = 16'd0;
                            end else begin
                                mode_next = (mode_reg == MODE_ON) ? MODE_OFF : MODE_ON;
                            end
                        end else begin
                            phase_timer_next = timer_inc[15:0];
                        end
                    end
                end
            end
            default: state_next = ST_READY;
        endcase

        out_next.buzzer_on = (mode_next == MODE_ON);
        out_next.tone_hz   = (mode_next == MODE_ON) ? tone_frequency_reg : 16'd0;
        out_next.mode      = mode_next;
        out_next.armed     = motion_flag_next;
        out_next.magnitude = last_mag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_READY;
            mode_reg        <= MODE_IDLE;
            accel_phase_reg <= 8'd0;
            light_phase_reg <= 8'd0;
            motion_flag_reg <= 1'b0;
            last_mag_reg    <= 16'd0;
            last_light_reg  <= '0;
            phase_timer_reg <= 16'd0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            accel_phase_reg <= accel_phase_next;
            light_phase_reg <= light_phase_next;
            motion_flag_reg <= motion_flag_next;
            last_mag_reg    <= last_mag_next;
            last_light_reg  <= last_light_next;
            phase_timer_reg <= phase_timer_next;
            if ((state_reg == ST_FINISH) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            motion_run_reg <= run_motion;
            light_in_reg   <= s_data.light_level;
        end
        if (mag_done) begin
            mag_in_reg <= mag_value;
        end
        if ((state_reg == ST_FINISH) && out_free) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mgla_magnitude.sv =====
`default_nettype none

module mgla_magnitude
    import mgla_pkg::*;
#(
    parameter int ACCEL_W = ACCEL_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [ACCEL_W-1:0] axis_x,
    input  wire logic signed [ACCEL_W-1:0] axis_y,
    input  wire logic signed [ACCEL_W-1:0] axis_z,
    output logic                           done,
    output logic [15:0]                    magnitude
);

    localparam int SUM_W  = 2 * ACCEL_W;
    localparam int REM_W  = ACCEL_W + 2;
    localparam int ITER_W = $clog2(ACCEL_W);
    localparam int CMP_W  = (ACCEL_W > 16) ? ACCEL_W : 16;

    typedef enum logic [2:0] {
        MS_IDLE   = 3'b001,
        MS_SQUARE = 3'b010,
        MS_ROOT   = 3'b100
    } mag_state_t;

    mag_state_t         state_reg, state_next;
    logic [1:0]         sq_cnt_reg, sq_cnt_next;
    logic [ITER_W-1:0]  it_cnt_reg, it_cnt_next;
    logic [ACCEL_W-1:0] op0_reg, op1_reg, op2_reg;
    logic [SUM_W-1:0]   prod_reg;
    logic [SUM_W-1:0]   acc_reg;
    logic [SUM_W-1:0]   n_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [ACCEL_W-1:0] root_reg;
    logic               done_reg, done_next;
    logic [15:0]        mag_reg;

    logic [ACCEL_W-1:0] ux, uy, uz;
    logic [ACCEL_W-1:0] abs_x, abs_y, abs_z;
    logic [REM_W-1:0]   rem_shift, trial;
    logic               take;
    logic [ACCEL_W-1:0] root_step;
    logic [CMP_W-1:0]   root_wide;

    function automatic logic [ACCEL_W-1:0] abs_val(input logic [ACCEL_W-1:0] v);
        logic [ACCEL_W-1:0] neg;
        neg = (~v) + {{(ACCEL_W-1){1'b0}}, 1'b1};
        return v[ACCEL_W-1] ? neg : v;
    endfunction

    assign ux    = axis_x;
    assign uy    = axis_y;
    assign uz    = axis_z;
    assign abs_x = abs_val(ux);
    assign abs_y = abs_val(uy);
    assign abs_z = abs_val(uz);

    assign rem_shift = {rem_reg[REM_W-3:0], n_reg[SUM_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign take      = (rem_shift >= trial);
    assign root_step = {root_reg[ACCEL_W-2:0], take};
    assign root_wide = CMP_W'(root_step);

    always_comb begin
        state_next  = state_reg;
        sq_cnt_next = sq_cnt_reg;
        it_cnt_next = it_cnt_reg;
        done_next   = 1'b0;
        unique case (state_reg)
            MS_IDLE: begin
                if (start) begin
                    state_next  = MS_SQUARE;
                    sq_cnt_next = 2'd0;
                end
            end
            MS_SQUARE: begin
                sq_cnt_next = sq_cnt_reg + 2'd1;
                if (sq_cnt_reg == 2'd3) begin
                    state_next  = MS_ROOT;
                    it_cnt_next = ITER_W'(ACCEL_W - 1);
                end
            end
            MS_ROOT: begin
                it_cnt_next = it_cnt_reg - {{(ITER_W-1){1'b0}}, 1'b1};
                if (it_cnt_reg == '0) begin
                    state_next = MS_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= MS_IDLE;
            sq_cnt_reg <= 2'd0;
            it_cnt_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            sq_cnt_reg <= sq_cnt_next;
            it_cnt_reg <= it_cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            MS_IDLE: begin
                op0_reg <= abs_x;
                op1_reg <= abs_y;
                op2_reg <= abs_z;
                acc_reg <= '0;
            end
            MS_SQUARE: begin
                prod_reg <= op0_reg * op0_reg;
                op0_reg  <= op1_reg;
                op1_reg  <= op2_reg;
                if (sq_cnt_reg != 2'd0) begin
                    acc_reg <= acc_reg + prod_reg;
                end
                if (sq_cnt_reg == 2'd3) begin
                    n_reg    <= acc_reg + prod_reg;
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
            end
            MS_ROOT: begin
                rem_reg  <= take ? (rem_shift - trial) : rem_shift;
                root_reg <= root_step;
                n_reg    <= {n_reg[SUM_W-3:0], 2'b00};
                if (it_cnt_reg == '0) begin
                    mag_reg <= (root_wide > CMP_W'(16'hFFFF)) ? 16'hFFFF : root_wide[15:0];
                end
            end
            default: ;
        endcase
    end

    assign done      = done_reg;
    assign magnitude = mag_reg;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgla_pkg::*;

    localparam int          PHASES          = 12;
    localparam int          ITEMS_PER_PHASE = 128;
    localparam int          SHORT_PHASE     = 60;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam longint      LUX_MAX         = (64'd1 << LIGHT_BITS) - 1;
    localparam longint      AXIS_MAX        = (64'd1 << (ACCEL_BITS - 1)) - 1;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam mgla_out_t              NO_RESULT    = '0;

    typedef struct {
        mgla_in_t  tick;
        bit        pinned;
        mgla_out_t result;
    } stim_row_t;

    logic                   aclk         = 1'b0;
    logic                   aresetn      = 1'b0;
    logic                   s_valid      = 1'b0;
    logic                   s_ready;
    mgla_in_t               s_data       = '0;
    logic                   m_valid;
    logic                   m_ready      = 1'b0;
    mgla_out_t              m_data;
    logic                   cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;

    // register copies
    logic [15:0] cfg_motion_th = RST_MOTION_THRESHOLD;
    logic [23:0] cfg_light_th  = RST_LIGHT_THRESHOLD;
    logic [7:0]  cfg_accel_div = RST_ACCEL_DIVIDER;
    logic [7:0]  cfg_light_div = RST_LIGHT_DIVIDER;
    logic [15:0] cfg_on_len    = RST_ON_TICKS;
    logic [15:0] cfg_off_len   = RST_OFF_TICKS;
    logic [15:0] cfg_tone      = RST_TONE_FREQUENCY;

    // alarm state copies
    logic [1:0]  st_mode    = MODE_IDLE;
    logic [7:0]  accel_ph   = '0;
    logic [7:0]  light_ph   = '0;
    logic        armed_q    = 1'b0;
    logic [15:0] last_mag   = '0;
    logic [23:0] last_lux   = '0;
    logic [15:0] buzz_timer = '0;

    mgla_out_t   expected_status[$];
    bit          pin_valid      = 1'b0;
    mgla_out_t   pin_result     = '0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned errors         = 0;
    int unsigned cycle_count    = 0;

    motion_gated_light_alarm uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [15:0] axis_mag(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

    function automatic logic [15:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return (r > 64'hFFFF) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [7:0] next_phase(input logic [7:0] ph, input logic [7:0] div);
        logic [8:0] nx;
        nx = {1'b0, ph} + 9'd1;
        return (nx >= {1'b0, div}) ? 8'd0 : nx[7:0];
    endfunction

    task automatic predict_status(input mgla_in_t t, output mgla_out_t r);
        logic [63:0] ax;
        logic [63:0] ay;
        logic [63:0] az;
        logic [15:0] mag;
        logic [15:0] dm;
        logic [23:0] lux;
        logic [23:0] dl;
        logic [15:0] len;
        logic [16:0] nt;
        logic        trig;
        lux  = t.light_level;
        trig = 1'b0;
        if (st_mode == MODE_IDLE) begin
            if (accel_ph == 0 && !armed_q) begin
                ax  = {48'd0, axis_mag(t.accel_x)};
                ay  = {48'd0, axis_mag(t.accel_y)};
                az  = {48'd0, axis_mag(t.accel_z)};
                mag = root_floor(ax * ax + ay * ay + az * az);
                dm  = (mag >= last_mag) ? mag - last_mag : last_mag - mag;
                if (dm > cfg_motion_th) armed_q = 1'b1;
                last_mag = mag;
            end
            if (light_ph == 0 && armed_q) begin
                if (lux > last_lux && (lux - last_lux) > cfg_light_th) trig = 1'b1;
                last_lux = lux;
            end
            accel_ph = next_phase(accel_ph, cfg_accel_div);
            light_ph = next_phase(light_ph, cfg_light_div);
            if (trig) begin
                st_mode    = MODE_ON;
                armed_q    = 1'b0;
                buzz_timer = '0;
            end
        end else begin
            len = (st_mode == MODE_ON) ? cfg_on_len : cfg_off_len;
            nt  = {1'b0, buzz_timer} + 17'd1;
            if (nt >= {1'b0, len}) begin
                buzz_timer = '0;
                dl = (lux >= last_lux) ? lux - last_lux : last_lux - lux;
                if (dl > cfg_light_th) begin
                    st_mode  = MODE_IDLE;
                    last_lux = '0;
                    last_mag = '0;
                end else begin
                    st_mode = (st_mode == MODE_ON) ? MODE_OFF : MODE_ON;
                end
            end else begin
                buzz_timer = nt[15:0];
            end
        end
        r.buzzer_on = (st_mode == MODE_ON);
        r.tone_hz   = (st_mode == MODE_ON) ? cfg_tone : 16'd0;
        r.mode      = st_mode;
        r.armed     = armed_q;
        r.magnitude = last_mag;
    endtask

    function automatic stim_row_t stim_row(input int x, input int y, input int z,
                                           input int lux, input bit pinned,
                                           input mgla_out_t res);
        stim_row_t r;
        r.tick.accel_x     = 16'(x);
        r.tick.accel_y     = 16'(y);
        r.tick.accel_z     = 16'(z);
        r.tick.light_level = 24'(lux);
        r.pinned           = pinned;
        r.result           = res;
        return r;
    endfunction

    // near-threshold steps around the stored levels, small random axes and raw noise
    function automatic mgla_in_t make_tick();
        mgla_in_t    t;
        logic [95:0] noise;
        longint      lux;
        longint      tgt;
        longint      th;
        int unsigned pick;
        noise = {$urandom, $urandom, $urandom};
        t     = noise[71:0];
        if ($urandom_range(99) < 12) return t;
        pick = $urandom_range(99);
        if (pick >= 40 && pick < 75) begin
            tgt = longint'(last_mag);
            th  = longint'(cfg_motion_th);
            case ($urandom_range(4))
                0: tgt = tgt + th + 1;
                1: tgt = tgt + th;
                2: tgt = tgt - th - 1;
                3: tgt = tgt - th;
                default: tgt = tgt + longint'($urandom_range(16)) - 8;
            endcase
            if (tgt < 0) tgt = 0;
            if (tgt > AXIS_MAX) tgt = AXIS_MAX;
            t.accel_x = $urandom_range(1) ? -16'(tgt) : 16'(tgt);
            t.accel_y = '0;
            t.accel_z = '0;
        end else if (pick >= 75) begin
            t.accel_x = 16'(int'($urandom_range(2000)) - 1000);
            t.accel_y = 16'(int'($urandom_range(2000)) - 1000);
            t.accel_z = 16'(int'($urandom_range(2000)) - 1000);
        end
        lux = longint'(last_lux);
        th  = longint'(cfg_light_th);
        case ($urandom_range(9))
            0, 1, 2: lux = lux + th + 1;
            3:       lux = lux + th;
            4:       lux = lux - th - 1;
            5:       lux = lux - th;
            6, 7:    lux = lux + longint'($urandom_range(64)) - 32;
            default: lux = longint'(t.light_level);
        endcase
        if (lux < 0) lux = 0;
        if (lux > LUX_MAX) lux = LUX_MAX;
        t.light_level = lux[23:0];
        return t;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = val;
        case (idx)
            REG_MOTION_THRESHOLD: cfg_motion_th = val[15:0];
            REG_LIGHT_THRESHOLD:  cfg_light_th  = val[23:0];
            REG_ACCEL_DIVIDER:    cfg_accel_div = val[7:0];
            REG_LIGHT_DIVIDER:    cfg_light_div = val[7:0];
            REG_ON_TICKS:         cfg_on_len    = val[15:0];
            REG_OFF_TICKS:        cfg_off_len   = val[15:0];
            REG_TONE_FREQUENCY:   cfg_tone      = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_write_en = 1'b0;
    endtask

    task automatic send_tick(input mgla_in_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_data  = t;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (expected_status.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : scoreboard
        mgla_out_t want;
        mgla_out_t pred;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    errors++;
                    $display("%0t: result with no request waiting, expected none actual %h",
                             $time, m_data);
                end else begin
                    want = expected_status.pop_front();
                    check_field("buzzer_on", want.buzzer_on, m_data.buzzer_on);
                    check_field("tone_hz",   want.tone_hz,   m_data.tone_hz);
                    check_field("mode",      want.mode,      m_data.mode);
                    check_field("armed",     want.armed,     m_data.armed);
                    check_field("magnitude", want.magnitude, m_data.magnitude);
                end
            end
            if (s_valid && s_ready) begin
                predict_status(s_data, pred);
                expected_status.push_back(pin_valid ? pin_result : pred);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        stim_row_t   dir_rows[$];
        stim_row_t   r;
        int          n;
        logic [15:0] mth;
        logic [23:0] lth;
        logic [7:0]  adiv;
        logic [7:0]  ldiv;
        logic [15:0] onl;
        logic [15:0] offl;
        logic [15:0] tone;

        dir_rows.push_back(stim_row(0, 0, 0, 0, 1'b1,
                           mgla_out_t'{1'b0, 16'd0, MODE_IDLE, 1'b0, 16'd0}));
        dir_rows.push_back(stim_row(-32768, -32768, -32768, 24'hFFFFFF, 1'b1,
                           mgla_out_t'{1'b1, 16'd3156, MODE_ON, 1'b0, 16'd56755}));
        dir_rows.push_back(stim_row(0, 0, 0, 24'hFFFFFF, 1'b1,
                           mgla_out_t'{1'b1, 16'd3156, MODE_ON, 1'b0, 16'd56755}));
        dir_rows.push_back(stim_row(0, 0, 0, 24'hFFFFFF, 1'b1,
                           mgla_out_t'{1'b0, 16'd0, MODE_OFF, 1'b0, 16'd56755}));
        dir_rows.push_back(stim_row(0, 0, 0, 0, 1'b1,
                           mgla_out_t'{1'b0, 16'd0, MODE_IDLE, 1'b0, 16'd0}));
        dir_rows.push_back(stim_row(201, 0, 0, 300, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(32767, 32767, 32767, 601, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 601, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 901, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 300, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(200, 0, 0, 0, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 0, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(32767, 32767, 32767, 0, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(-1, -1, -1, 1000, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 1000, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 700, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(0, 0, 0, 699, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(12345, -23456, 345, 24'h5A5A5A, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(-32768, 32767, 0, 24'h123456, 1'b0, NO_RESULT));
        dir_rows.push_back(stim_row(32767, -32768, -1, 24'hA5A5A5, 1'b0, NO_RESULT));

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        write_reg(REG_MOTION_THRESHOLD, 24'hAB00C8);
        write_reg(REG_LIGHT_THRESHOLD,  24'd300);
        write_reg(REG_ACCEL_DIVIDER,    24'd1);
        write_reg(REG_LIGHT_DIVIDER,    24'd1);
        write_reg(REG_ON_TICKS,         24'd2);
        write_reg(REG_OFF_TICKS,        24'd0);
        write_reg(REG_TONE_FREQUENCY,   24'd3156);
        write_reg(REG_UNMAPPED,         24'hFFFFFF);

        foreach (dir_rows[i]) begin
            r          = dir_rows[i];
            pin_valid  = r.pinned;
            pin_result = r.result;
            send_tick(r.tick);
        end
        pin_valid = 1'b0;
        s_valid   = 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            mth  = (ph == 3) ? 16'hFFFF : (ph == 5) ? 16'd0 : 16'($urandom_range(400));
            lth  = (ph == 4) ? 24'hFFFFFF : (ph == 6) ? 24'd0 : 24'($urandom_range(600));
            adiv = (ph == 7) ? 8'd255 : (ph == 2) ? 8'd0 : 8'($urandom_range(4, 1));
            ldiv = (ph == 7) ? 8'd255 : (ph == 8) ? 8'd0 : 8'($urandom_range(6, 1));
            onl  = (ph == 9) ? 16'hFFFF : (ph == 10) ? 16'd0 : 16'($urandom_range(12, 1));
            offl = (ph == 9) ? 16'hFFFF : (ph == 11) ? 16'd0 : 16'($urandom_range(12, 1));
            tone = (ph == 1) ? 16'd0 : (ph == 2) ? 16'hFFFF : 16'($urandom);
            write_reg(REG_MOTION_THRESHOLD, {8'd0, mth});
            write_reg(REG_LIGHT_THRESHOLD,  lth);
            write_reg(REG_ACCEL_DIVIDER,    {16'd0, adiv});
            write_reg(REG_LIGHT_DIVIDER,    {16'd0, ldiv});
            write_reg(REG_ON_TICKS,         {8'd0, onl});
            write_reg(REG_OFF_TICKS,        {8'd0, offl});
            write_reg(REG_TONE_FREQUENCY,   {8'd0, tone});
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            n = (ph == 7 || ph == 9) ? SHORT_PHASE : ITEMS_PER_PHASE;
            for (int k = 0; k < n; k++) begin
                if (k == n / 2 && ph % 3 == 0) begin
                    // hold off until every pending result has drained
                    s_valid = 1'b0;
                    wait_drained();
                end
                send_tick(make_tick());
            end
            s_valid = 1'b0;
        end

        wait_drained();
        repeat (30) @(negedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
